// ----- rtl/multi_stack_shared_buffer_defines.svh -----
// Assertion macros used by the checker file of the shared-buffer stack block.
`ifndef MULTI_STACK_SHARED_BUFFER_DEFINES_SVH
`define MULTI_STACK_SHARED_BUFFER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define MSSB_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define MSSB_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mssb_pkg.sv -----
// Types, codes and default sizes for the shared-buffer stack block.
`default_nettype none
package mssb_pkg;

  localparam int NUM_STACKS_DEF = 8;
  localparam int CAPACITY_DEF   = 256;

  localparam int NUM_W   = 4;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int S_TDATA_W = ((NUM_W + VALUE_W + 7) / 8) * 8;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BADSTACK = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

endpackage
`default_nettype wire

// ----- rtl/mssb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mssb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/multi_stack_shared_buffer.sv -----
// Top level: several LIFO stacks chained through one shared slot store.
//
//  channel  dir  tdata (low bit up)                     tuser
//  s_axis   in   stack_number[3:0], push_value[35:4]    operation (0 push, 1 pop)
//  m_axis   out  popped_value[31:0]                     status[1:0]
//
// Each word is accepted, then committed: the accept cycle reads the link and element RAMs
// at the chosen slot; the EXEC state then commits links, heads and the result register,
// waiting while the output register holds a stalled result.
// Reset needs no clearing pass: a high-water mark stands in for the initial free chain.
// A stalled result holds the commit cycle; a new word is still accepted while a
// result waits in the output register.
`default_nettype none
module multi_stack_shared_buffer
  import mssb_pkg::*;
#(
  parameter int NUM_STACKS = NUM_STACKS_DEF,
  parameter int CAPACITY   = CAPACITY_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata_i,  // stack_number, push_value
  input  wire logic                 s_axis_tuser_i,  // operation
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic      [VALUE_W-1:0]   m_axis_tdata_o,  // popped_value
  output logic      [STAT_W-1:0]    m_axis_tuser_o   // status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam logic [LW-1:0] NONE = LW'(CAPACITY);

  state_e state_q, state_d;

  logic [LW-1:0] heads_q [NUM_STACKS];
  logic [LW-1:0] free_head_q;
  logic [LW-1:0] hwm_q;

  logic               op_q;
  logic [SW-1:0]      sidx_q;
  logic [VALUE_W-1:0] val_q;
  logic               bad_q;
  logic [LW-1:0]      slot_q;
  logic               fresh_q;

  logic               out_valid_q;
  logic [STAT_W-1:0]  out_stat_q;
  logic [VALUE_W-1:0] out_data_q;

  logic               accept, commit;
  logic [NUM_W-1:0]   in_num;
  logic               in_op, in_bad;
  logic [SW-1:0]      in_sidx;
  logic [LW-1:0]      in_slot;
  logic [LW-1:0]      link_rdata, link_raw, link_next, link_wdata;
  logic [VALUE_W-1:0] elem_rdata;
  logic               slot_none, link_we, elem_we;
  logic [STAT_W-1:0]  res_stat;
  logic [VALUE_W-1:0] res_data;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign commit = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready_i);

  assign in_num  = s_axis_tdata_i[NUM_W-1:0];
  assign in_op   = s_axis_tuser_i;
  assign in_bad  = (in_num == '0) || (int'(in_num) > NUM_STACKS);
  assign in_sidx = SW'(in_num - NUM_W'(1));
  assign in_slot = (in_op == OP_POP) ? heads_q[in_sidx] : free_head_q;

  // Slots at or above the high-water mark were never written: their link is slot+1.
  assign link_raw  = fresh_q ? LW'(slot_q + LW'(1)) : link_rdata;
  assign link_next = (link_raw > NONE) ? NONE : link_raw;
  assign slot_none = (slot_q >= NONE);

  always_comb begin
    res_stat   = STAT_OK;
    res_data   = '0;
    link_we    = 1'b0;
    elem_we    = 1'b0;
    link_wdata = free_head_q;
    if (bad_q) begin
      res_stat = STAT_BADSTACK;
    end else if (op_q == OP_PUSH) begin
      link_wdata = heads_q[sidx_q];
      if (slot_none) begin
        res_stat = STAT_FULL;
      end else begin
        link_we = commit;
        elem_we = commit;
      end
    end else begin
      if (slot_none) begin
        res_stat = STAT_EMPTY;
      end else begin
        link_we  = commit;
        res_data = elem_rdata;
      end
    end
  end

  mssb_ram #(
    .WIDTH(LW),
    .DEPTH(CAPACITY)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(slot_q[AW-1:0]),
    .wdata_i(link_wdata),
    .re_i   (accept),
    .raddr_i(in_slot[AW-1:0]),
    .rdata_o(link_rdata)
  );

  mssb_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CAPACITY)
  ) u_elem_ram (
    .clk_i  (clk_i),
    .we_i   (elem_we),
    .waddr_i(slot_q[AW-1:0]),
    .wdata_i(val_q),
    .re_i   (accept),
    .raddr_i(in_slot[AW-1:0]),
    .rdata_o(elem_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_EXEC;
      S_EXEC:  if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_op;
      sidx_q  <= in_sidx;
      val_q   <= s_axis_tdata_i[NUM_W+VALUE_W-1:NUM_W];
      bad_q   <= in_bad;
      slot_q  <= in_slot;
      fresh_q <= (in_slot >= hwm_q);
    end
    if (commit) begin
      out_stat_q <= res_stat;
      out_data_q <= res_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      free_head_q <= '0;
      hwm_q       <= '0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        heads_q[i] <= NONE;
      end
    end else begin
      state_q <= state_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (commit && !bad_q && !slot_none) begin
        if (op_q == OP_PUSH) begin
          free_head_q     <= link_next;
          heads_q[sidx_q] <= slot_q;
          if (fresh_q) begin
            hwm_q <= LW'(hwm_q + LW'(1));
          end
        end else begin
          heads_q[sidx_q] <= link_next;
          free_head_q     <= slot_q;
        end
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_stat_q;

endmodule
`default_nettype wire

// ----- rtl/mssb_checker.sv -----
// Port-level checker for the shared-buffer stack block, bound to the top level.
`default_nettype none
`include "multi_stack_shared_buffer_defines.svh"
module mssb_checker
  import mssb_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid_i,
  input wire logic                 s_axis_tready_o,
  input wire logic                 m_axis_tvalid_o,
  input wire logic                 m_axis_tready_i,
  input wire logic [VALUE_W-1:0]   m_axis_tdata_o,  // popped_value
  input wire logic [STAT_W-1:0]    m_axis_tuser_o   // status
);

  logic s_acc, m_stall;

  assign s_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign m_stall = m_axis_tvalid_o && !m_axis_tready_i;

  // a stalled result word holds
  `MSSB_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_stall, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "result word changed while stalled")

  // one word in flight: no accept right after an accept
  `MSSB_ASSERT_NXT(a_one_inflight, clk_i, rst_ni, s_acc, !s_axis_tready_o, "input taken while a word is in flight")

  // only a successful pop carries data
  `MSSB_ASSERT_IMP(a_zero_data, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tuser_o != STAT_OK), m_axis_tdata_o == '0, "nonzero data with non-ok status")

  // with a free output register the result shows after the EXEC state commits it
  `MSSB_ASSERT_IMP(a_latency, clk_i, rst_ni, s_acc && !m_axis_tvalid_o, ##2 m_axis_tvalid_o, "result missing two cycles after accept")

endmodule

bind multi_stack_shared_buffer mssb_checker u_mssb_checker (.*);
`default_nettype wire

// ----- verif/multi_stack_shared_buffer_test.sv -----
// Self-checking testbench for the shared-buffer multi-stack block: driven stream, scoreboard.
`timescale 1ns / 1ps
module multi_stack_shared_buffer_test;
  import mssb_pkg::*;

  localparam int SLOTS      = CAPACITY_DEF;
  localparam int STACKS     = NUM_STACKS_DEF;
  localparam int LINK_W     = $clog2(SLOTS + 1);
  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(SLOTS);
  localparam int MAX_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    logic               op;
    logic [NUM_W-1:0]   stk;
    logic [VALUE_W-1:0] val;
  } stack_cmd_t;

  typedef struct {
    logic [STAT_W-1:0]  status;
    logic [VALUE_W-1:0] value;
  } stack_rsp_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [VALUE_W-1:0]   m_tdata;
  logic [STAT_W-1:0]    m_tuser;

  multi_stack_shared_buffer i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Shadow copy of the stack store
  logic [VALUE_W-1:0] slot_values [SLOTS];
  logic [LINK_W-1:0]  slot_links  [SLOTS];
  logic [LINK_W-1:0]  top_of      [STACKS];
  logic [LINK_W-1:0]  free_top;

  stack_cmd_t cmd_q[$];
  stack_rsp_t rsp_q[$];
  stack_cmd_t cur_cmd;
  logic       cmd_taken = 1'b0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         err_count = 0;
  int         cycle_count = 0;

  function automatic void clear_stacks();
    for (int i = 0; i < SLOTS; i++) begin
      slot_values[i] = '0;
      slot_links[i]  = (i == SLOTS - 1) ? LINK_NONE : LINK_W'(i + 1);
    end
    for (int i = 0; i < STACKS; i++) top_of[i] = LINK_NONE;
    free_top = '0;
  endfunction

  function automatic stack_rsp_t run_stack_op(stack_cmd_t c);
    stack_rsp_t r;
    int s;
    logic [LINK_W-1:0] slot;
    r.status = STAT_OK;
    r.value  = '0;
    if (c.stk < 1 || c.stk > STACKS) begin
      r.status = STAT_BADSTACK;
    end else begin
      s = int'(c.stk) - 1;
      if (c.op == OP_PUSH) begin
        slot = free_top;
        if (slot >= SLOTS) begin
          r.status = STAT_FULL;
        end else begin
          slot_values[slot] = c.val;
          free_top = slot_links[slot];
          if (free_top > SLOTS) free_top = LINK_NONE;
          slot_links[slot] = top_of[s];
          top_of[s] = slot;
        end
      end else begin
        slot = top_of[s];
        if (slot >= SLOTS) begin
          r.status = STAT_EMPTY;
        end else begin
          top_of[s] = slot_links[slot];
          if (top_of[s] > SLOTS) top_of[s] = LINK_NONE;
          slot_links[slot] = free_top;
          free_top = slot;
          r.value = slot_values[slot];
        end
      end
    end
    return r;
  endfunction

  function automatic void add_cmd(logic op, int stk, logic [VALUE_W-1:0] val);
    stack_cmd_t c;
    c.op  = op;
    c.stk = NUM_W'(stk);
    c.val = val;
    cmd_q.push_back(c);
  endfunction

  // push_pct sets the fill/drain bias; a few words hit out-of-range stack numbers
  task automatic add_random_cmds(int n, int push_pct);
    logic [VALUE_W-1:0] v;
    int stk;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: v = 32'h8000_0000;
        1: v = 32'h7fff_ffff;
        2: v = 32'h0000_0000;
        3: v = 32'hffff_ffff;
        default: v = $urandom;
      endcase
      stk = ($urandom_range(19) == 0) ? $urandom_range(15) : $urandom_range(STACKS, 1);
      add_cmd(($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP, stk, v);
    end
  endtask

  // checked on the rising edge, where the queues and tvalid are settled
  task automatic wait_drained();
    while (cmd_q.size() != 0 || s_tvalid || rsp_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic void log_error(string msg);
    if (err_count < 10) $display("ERROR at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endfunction

  // Driver: next word goes out on the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || cmd_taken) begin
      cmd_taken = 1'b0;
      if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_cmd = cmd_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - NUM_W - VALUE_W){1'b0}}, cur_cmd.val, cur_cmd.stk};
        s_tuser  <= cur_cmd.op;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor and scoreboard on the rising edge
  always @(posedge clk_i) begin
    stack_rsp_t want;
    cycle_count++;
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        rsp_q.push_back(run_stack_op(cur_cmd));
        cmd_taken = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        if (rsp_q.size() == 0) begin
          log_error($sformatf("unexpected word: status %0d value %h", m_tuser, m_tdata));
        end else begin
          want = rsp_q.pop_front();
          if (want.status !== m_tuser || want.value !== m_tdata)
            log_error($sformatf("expected status %0d value %h, got status %0d value %h",
                                want.status, want.value, m_tuser, m_tdata));
        end
      end
    end
    if (cycle_count > MAX_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    clear_stacks();
    send_idle_pct = 13;
    recv_idle_pct = 86;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes, empty pops, bad stack numbers
    add_cmd(OP_PUSH, 1, 32'h8000_0000);
    add_cmd(OP_PUSH, STACKS, 32'h7fff_ffff);
    add_cmd(OP_PUSH, 1, 32'h0000_0000);
    add_cmd(OP_PUSH, STACKS, 32'hffff_ffff);
    add_cmd(OP_POP, STACKS, 32'hffff_ffff);
    add_cmd(OP_POP, STACKS, 32'h0000_0000);
    add_cmd(OP_POP, STACKS, 32'h1234_5678);
    add_cmd(OP_POP, 1, 32'h0);
    add_cmd(OP_POP, 1, 32'h0);
    add_cmd(OP_POP, 1, 32'h0);
    add_cmd(OP_PUSH, 0, 32'hdead_beef);
    add_cmd(OP_POP, 0, 32'h0);
    add_cmd(OP_PUSH, STACKS + 1, 32'h5555_5555);
    add_cmd(OP_PUSH, 15, 32'haaaa_aaaa);
    add_cmd(OP_POP, 15, 32'hffff_ffff);
    add_cmd(OP_POP, 2, 32'h0);
    add_cmd(OP_PUSH, 4, 32'haaaa_aaaa);
    add_cmd(OP_PUSH, 4, 32'h5555_5555);
    add_cmd(OP_POP, 4, 32'h0);
    add_cmd(OP_POP, 4, 32'h0);

    // Fill-heavy: runs the free list dry and exercises full refusals
    add_random_cmds(360, 92);
    wait_drained();

    send_idle_pct = 86;
    recv_idle_pct = 13;
    // Drain-heavy: empties every stack
    add_random_cmds(370, 10);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_cmds(120, 80);
    add_random_cmds(120, 25);
    add_random_cmds(120, 55);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0 && rsp_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
